// File: hdl/assert_macros.svh
// assertion macros shared by the palette indexer rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed: invariant");

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`endif

// File: hdl/rgbpal_pkg.sv
// types, constants and helpers for the rgb555 palette indexer
// no dependencies; used by rgbpal_engine and rgb555_palette_indexer
package rgbpal_pkg;

    localparam int DEFAULT_DEPTH = 256;
    localparam int CHAN_BITS     = 5;
    localparam int COLOR_W       = 3 * CHAN_BITS;

    // request kinds
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic               start_image;
        logic [COLOR_W-1:0] color;
        logic [7:0]         sel;
    } rgbpal_req_t;

    typedef struct packed {
        logic [7:0]         index;
        logic [COLOR_W-1:0] color;
        logic               is_new;
        logic               overflow;
        logic               entry_valid;
        logic [8:0]         count;
    } rgbpal_result_t;

    // 8-bit channel divided by 8 keeps the top five bits
    function automatic logic [COLOR_W-1:0] quantize(input logic [7:0] r,
                                                     input logic [7:0] g,
                                                     input logic [7:0] b);
        return {r[7:8-CHAN_BITS], g[7:8-CHAN_BITS], b[7:8-CHAN_BITS]};
    endfunction

    // 5-bit channel times 8
    function automatic logic [7:0] expand(input logic [CHAN_BITS-1:0] c);
        return {c, 3'b000};
    endfunction

endpackage

// File: hdl/rgbpal_mem.sv
// palette store: one write port, one read port with registered read data
// no package dependencies
module rgbpal_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 15
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] store_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            store_mem[wr_addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= store_mem[rd_addr];
    end

endmodule

// File: hdl/rgbpal_engine.sv
// search / append sequencer around the palette store, holds the entry count
// depends on rgbpal_pkg and assert_macros.svh
`include "assert_macros.svh"

module rgbpal_engine #(
    parameter int DEPTH = rgbpal_pkg::DEFAULT_DEPTH,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_go,
    input  rgbpal_pkg::rgbpal_req_t            in_req,
    output logic                               in_ready,
    output logic                               res_valid,
    input  logic                               res_take,
    output rgbpal_pkg::rgbpal_result_t         res,
    output logic                               mem_we,
    output logic [AW-1:0]                      mem_wr_addr,
    output logic [rgbpal_pkg::COLOR_W-1:0]     mem_wdata,
    output logic [AW-1:0]                      mem_rd_addr,
    input  logic [rgbpal_pkg::COLOR_W-1:0]     mem_rdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_RDA  = 3'd2;
    localparam logic [2:0] ST_RDB  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                       state_reg, state_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic [CW-1:0]                    ptr_reg, ptr_next;
    logic                             pend_reg, pend_next;
    logic [AW-1:0]                    pend_idx_reg, pend_idx_next;
    logic [rgbpal_pkg::COLOR_W-1:0]   color_reg, color_next;
    logic [7:0]                       sel_reg, sel_next;
    rgbpal_pkg::rgbpal_result_t       res_reg, res_next;
    logic                             hit;

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;
    assign hit       = pend_reg && (mem_rdata == color_reg);
    assign mem_wdata = color_reg;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        color_next    = color_reg;
        sel_next      = sel_reg;
        res_next      = res_reg;
        mem_we        = 1'b0;
        mem_wr_addr   = count_reg[AW-1:0];
        mem_rd_addr   = (state_reg == ST_SCAN) ? ptr_reg[AW-1:0] : AW'(sel_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (in_go) begin
                    if (in_req.start_image) begin
                        count_next = '0;
                    end
                    color_next = in_req.color;
                    sel_next   = in_req.sel;
                    ptr_next   = '0;
                    unique case (in_req.req_type)
                        rgbpal_pkg::REQ_PIXEL: state_next = ST_SCAN;
                        rgbpal_pkg::REQ_READ:  state_next = ST_RDA;
                        default:               state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                res_next.color       = color_reg;
                res_next.entry_valid = 1'b0;
                if (hit) begin
                    res_next.index    = 8'(pend_idx_reg);
                    res_next.is_new   = 1'b0;
                    res_next.overflow = 1'b0;
                    res_next.count    = 9'(count_reg);
                    state_next        = ST_DONE;
                end else if (ptr_reg < count_reg) begin
                    // one entry issued per cycle, compared the cycle after
                    pend_next     = 1'b1;
                    pend_idx_next = ptr_reg[AW-1:0];
                    ptr_next      = ptr_reg + CW'(1);
                end else if (!pend_reg) begin
                    if (count_reg != CW'(DEPTH)) begin
                        mem_we            = 1'b1;
                        count_next        = count_reg + CW'(1);
                        res_next.index    = 8'(count_reg);
                        res_next.is_new   = 1'b1;
                        res_next.overflow = 1'b0;
                        res_next.count    = 9'(count_reg + CW'(1));
                    end else begin
                        res_next.index    = '0;
                        res_next.is_new   = 1'b0;
                        res_next.overflow = 1'b1;
                        res_next.count    = 9'(count_reg);
                    end
                    state_next = ST_DONE;
                end
            end
            ST_RDA: begin
                state_next = ST_RDB;
            end
            ST_RDB: begin
                res_next.index    = sel_reg;
                res_next.is_new   = 1'b0;
                res_next.overflow = 1'b0;
                res_next.count    = 9'(count_reg);
                if (32'(sel_reg) < 32'(count_reg)) begin
                    res_next.entry_valid = 1'b1;
                    res_next.color       = mem_rdata;
                end else begin
                    res_next.entry_valid = 1'b0;
                    res_next.color       = '0;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg      <= ptr_next;
        pend_idx_reg <= pend_idx_next;
        color_reg    <= color_next;
        sel_reg      <= sel_next;
        res_reg      <= res_next;
    end

    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CW'(DEPTH))
    `ASSERT_NEXT(a_append_counts, aclk, aresetn, mem_we, count_reg == $past(count_reg) + CW'(1))
    `ASSERT_IMPL(a_new_xor_ovf, aclk, aresetn, res_valid, !(res_reg.is_new && res_reg.overflow))

endmodule

// File: hdl/rgb555_palette_indexer.sv
// top level of the rgb555 palette indexer: stream ports, quantizer, output register
// depends on rgbpal_pkg, rgbpal_mem and rgbpal_engine
//
//  channel | dir | width               | contents
//  --------+-----+---------------------+---------------------------------------------
//  s_      | in  | tdata 32, tuser 2   | pixel channels and read index, request flags
//  m_      | out | tdata 64            | index, color, flags, expanded rgb, count
//
// a new color is searched from entry 0 up: one entry read per cycle, compared in the cycle after;
// a hit ends early
// a read-back request takes one memory read plus sequencing
// a result waits in the output register while the next request is taken and worked
// reset clears the entry count and the sequencer; the store contents are not cleared
// a stalled result holds the sequencer in its done state until the register frees
module rgb555_palette_indexer #(
    parameter int PALETTE_DEPTH = rgbpal_pkg::DEFAULT_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // red_in[7:0], green_in[15:8], blue_in[23:16], entry_select[31:24]
    input  logic [31:0] s_tdata,
    // req_type[0], start_image[1]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // palette_index[7:0], packed_color[22:8], is_new_entry[23], overflow[24],
    // entry_valid[25], red_out[33:26], green_out[41:34], blue_out[49:42],
    // entry_count[58:50], zero fill [63:59]
    output logic [63:0] m_tdata
);

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CW = $clog2(PALETTE_DEPTH + 1);
    localparam int CB = rgbpal_pkg::CHAN_BITS;

    rgbpal_pkg::rgbpal_req_t          req;
    rgbpal_pkg::rgbpal_result_t       res;
    logic                             eng_ready;
    logic                             res_valid;
    logic                             res_take;
    logic                             mem_we;
    logic [AW-1:0]                    mem_wr_addr;
    logic [AW-1:0]                    mem_rd_addr;
    logic [rgbpal_pkg::COLOR_W-1:0]   mem_wdata;
    logic [rgbpal_pkg::COLOR_W-1:0]   mem_rdata;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [63:0]                      m_tdata_reg, m_tdata_next;

    // request fields: color is quantized on the way in
    assign req.req_type    = s_tuser[0];
    assign req.start_image = s_tuser[1];
    assign req.color       = rgbpal_pkg::quantize(s_tdata[7:0], s_tdata[15:8],
                                                  s_tdata[23:16]);
    assign req.sel         = s_tdata[31:24];

    assign s_tready = eng_ready;

    rgbpal_mem #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (AW),
        .DW    (rgbpal_pkg::COLOR_W)
    ) u_mem (
        .aclk    (aclk),
        .we      (mem_we),
        .wr_addr (mem_wr_addr),
        .wdata   (mem_wdata),
        .rd_addr (mem_rd_addr),
        .rdata   (mem_rdata)
    );

    rgbpal_engine #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_go       (s_tvalid && eng_ready),
        .in_req      (req),
        .in_ready    (eng_ready),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res),
        .mem_we      (mem_we),
        .mem_wr_addr (mem_wr_addr),
        .mem_wdata   (mem_wdata),
        .mem_rd_addr (mem_rd_addr),
        .mem_rdata   (mem_rdata)
    );

    // output register loads when empty or being drained this cycle
    assign res_take = res_valid && (!m_tvalid_reg || m_tready);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_take) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {5'b00000,
                             res.count,
                             rgbpal_pkg::expand(res.color[CB-1:0]),
                             rgbpal_pkg::expand(res.color[2*CB-1:CB]),
                             rgbpal_pkg::expand(res.color[3*CB-1:2*CB]),
                             res.entry_valid,
                             res.overflow,
                             res.is_new,
                             res.color,
                             res.index};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: tb/testbench.sv
// self-checking testbench for rgb555_palette_indexer: directed rows, then images of random pixels
// depends on rgbpal_pkg and the rgb555_palette_indexer rtl; reads no files
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 12;
    localparam int DEPTH         = rgbpal_pkg::DEFAULT_DEPTH;
    localparam int NUM_DIRECTED  = 17;
    localparam int RANDOM_TARGET = 1850;
    // pressure points and the quiet tail, counted in accepted requests
    localparam int HOLD_AT       = 700;
    localparam int PAUSE_AT      = 1100;
    localparam int QUIET_AT      = 1600;
    localparam int HOLD_CYCLES   = 700;
    // allow well past a full-palette search
    localparam int DRAIN_CYCLES  = 300;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int MAX_PRINTED   = 50;

    // one request as the host sees it
    typedef struct packed {
        logic       req;
        logic       start;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] sel;
    } pal_request_t;

    // one result, fields in the order they sit on m_tdata from bit 0 up
    typedef struct packed {
        logic [7:0]  index;
        logic [14:0] color;
        logic        is_new;
        logic        overflow;
        logic        entry_valid;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [8:0]  count;
    } pal_result_t;

    typedef struct packed {
        pal_request_t rq;
        logic         given;   // golden result typed in below
        pal_result_t  golden;
    } directed_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    // predictor state: the palette as the block should hold it
    logic [14:0] model_colors [0:DEPTH-1];
    int          model_count = 0;

    pal_result_t   pending_results [$];
    directed_row_t directed_rows [NUM_DIRECTED];
    logic [14:0]   color_pool [0:319];

    int error_count    = 0;
    int results_seen   = 0;
    int requests_sent  = 0;
    int cycle_count    = 0;
    int no_gap_left    = 0;
    bit sender_idle_on = 1'b1;
    bit receiver_idle_on = 1'b1;
    bit long_hold_req  = 1'b0;

    pal_result_t mon_got;
    pal_result_t mon_want;

    rgb555_palette_indexer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // palette predictor: start flag clears the count first, then the request is served
    function automatic pal_result_t palette_step(input pal_request_t rq);
        pal_result_t res;
        logic [14:0] col;
        logic        found;
        int          slot;
        res   = '0;
        col   = '0;
        found = 1'b0;
        slot  = 0;
        if (rq.start)
            model_count = 0;
        if (rq.req == rgbpal_pkg::REQ_READ) begin
            res.index = rq.sel;
            // entries at or above the count read back as zero
            if (int'(rq.sel) < model_count) begin
                col             = model_colors[rq.sel];
                res.entry_valid = 1'b1;
                res.color       = col;
            end
        end else begin
            // divide by 8 keeps the top five bits of each channel
            col = {5'(rq.red / 8), 5'(rq.green / 8), 5'(rq.blue / 8)};
            for (int i = 0; i < model_count; i++) begin
                if (!found && model_colors[i] == col) begin
                    found = 1'b1;
                    slot  = i;
                end
            end
            if (!found) begin
                if (model_count < DEPTH) begin
                    slot = model_count;
                    model_colors[slot] = col;
                    model_count++;
                    res.is_new = 1'b1;
                end else begin
                    // palette full: color is dropped and index 0 comes back
                    slot = 0;
                    res.overflow = 1'b1;
                end
            end
            res.index = 8'(slot);
            res.color = col;
        end
        if (res.entry_valid || rq.req == rgbpal_pkg::REQ_PIXEL) begin
            res.red   = 8'(res.color[14:10]) * 8'd8;
            res.green = 8'(res.color[9:5]) * 8'd8;
            res.blue  = 8'(res.color[4:0]) * 8'd8;
        end
        res.count = 9'(model_count);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("result %0d: %s is %0h, expected %0h", results_seen, what, got, want);
    endtask

    // offer one request from the falling edge until the block takes it
    task automatic send_request(input pal_request_t rq, input logic given,
                                input pal_result_t golden);
        pal_result_t want;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {rq.sel, rq.blue, rq.green, rq.red};
        s_tuser  <= {rq.start, rq.req};
        do @(posedge aclk); while (!s_tready);
        want = palette_step(rq);
        if (given)
            want = golden;
        pending_results = {pending_results, want};
        requests_sent++;
    endtask

    // random idle burst on the input side between transfers
    task automatic sender_gap();
        int gap;
        gap = 0;
        if (no_gap_left > 0)
            no_gap_left--;
        else if (sender_idle_on && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 13);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // directed rows; golden results only where they are obvious
    initial begin
        // read straight after reset: nothing stored yet
        directed_rows[0]  = '{'{rgbpal_pkg::REQ_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
                              '{8'd0, 15'h0000, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 9'd0}};
        directed_rows[1]  = '{'{rgbpal_pkg::REQ_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd255}, 1'b1,
                              '{8'd255, 15'h0000, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 9'd0}};
        // black and white extremes open the first image
        directed_rows[2]  = '{'{rgbpal_pkg::REQ_PIXEL, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
                              '{8'd0, 15'h0000, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 9'd1}};
        directed_rows[3]  = '{'{rgbpal_pkg::REQ_PIXEL, 1'b0, 8'd255, 8'd255, 8'd255, 8'd0},
                              1'b1,
                              '{8'd1, 15'h7FFF, 1'b1, 1'b0, 1'b0, 8'd248, 8'd248, 8'd248,
                                9'd2}};
        // low three bits vanish, so this hits black
        directed_rows[4]  = '{'{rgbpal_pkg::REQ_PIXEL, 1'b0, 8'd7, 8'd7, 8'd7, 8'd0}, 1'b1,
                              '{8'd0, 15'h0000, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 9'd2}};
        directed_rows[5]  = '{'{rgbpal_pkg::REQ_PIXEL, 1'b0, 8'd248, 8'd0, 8'd255, 8'd0},
                              1'b1,
                              '{8'd2, 15'h7C1F, 1'b1, 1'b0, 1'b0, 8'd248, 8'd0, 8'd248,
                                9'd3}};
        directed_rows[6]  = '{'{rgbpal_pkg::REQ_PIXEL, 1'b0, 8'd0, 8'd255, 8'd0, 8'd0}, 1'b1,
                              '{8'd3, 15'h03E0, 1'b1, 1'b0, 1'b0, 8'd0, 8'd248, 8'd0, 9'd4}};
        directed_rows[7]  = '{'{rgbpal_pkg::REQ_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd1}, 1'b1,
                              '{8'd1, 15'h7FFF, 1'b0, 1'b0, 1'b1, 8'd248, 8'd248, 8'd248,
                                9'd4}};
        // read at the count, one past the last entry
        directed_rows[8]  = '{'{rgbpal_pkg::REQ_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd4}, 1'b1,
                              '{8'd4, 15'h0000, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 9'd4}};
        directed_rows[9]  = '{'{rgbpal_pkg::REQ_PIXEL, 1'b0, 8'd131, 8'd66, 8'd200, 8'd0},
                              1'b0, '0};
        directed_rows[10] = '{'{rgbpal_pkg::REQ_PIXEL, 1'b0, 8'd135, 8'd70, 8'd207, 8'd0},
                              1'b0, '0};
        directed_rows[11] = '{'{rgbpal_pkg::REQ_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd4}, 1'b0, '0};
        // start flag on a read clears the count before the lookup
        directed_rows[12] = '{'{rgbpal_pkg::REQ_READ, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
                              '{8'd0, 15'h0000, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 9'd0}};
        // stored white no longer counts, so it is appended again
        directed_rows[13] = '{'{rgbpal_pkg::REQ_PIXEL, 1'b0, 8'd255, 8'd255, 8'd255, 8'd0},
                              1'b1,
                              '{8'd0, 15'h7FFF, 1'b1, 1'b0, 1'b0, 8'd248, 8'd248, 8'd248,
                                9'd1}};
        directed_rows[14] = '{'{rgbpal_pkg::REQ_PIXEL, 1'b1, 8'd255, 8'd250, 8'd249, 8'd0},
                              1'b0, '0};
        directed_rows[15] = '{'{rgbpal_pkg::REQ_PIXEL, 1'b0, 8'd8, 8'd16, 8'd24, 8'd0},
                              1'b0, '0};
        directed_rows[16] = '{'{rgbpal_pkg::REQ_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd1}, 1'b0, '0};
    end

    // result side ready: random stall bursts, plus one long hold-off on request
    initial begin : result_sink
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (receiver_idle_on && $urandom_range(0, 15) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // every result transfer is checked against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            mon_got = '{m_tdata[7:0], m_tdata[22:8], m_tdata[23], m_tdata[24], m_tdata[25],
                        m_tdata[33:26], m_tdata[41:34], m_tdata[49:42], m_tdata[58:50]};
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, index", mon_got.index, 0);
            end else begin
                mon_want = pending_results.pop_front();
                if (mon_got.index != mon_want.index)
                    report_mismatch("palette_index", mon_got.index, mon_want.index);
                if (mon_got.color != mon_want.color)
                    report_mismatch("packed_color", mon_got.color, mon_want.color);
                if (mon_got.is_new != mon_want.is_new)
                    report_mismatch("is_new_entry", mon_got.is_new, mon_want.is_new);
                if (mon_got.overflow != mon_want.overflow)
                    report_mismatch("overflow", mon_got.overflow, mon_want.overflow);
                if (mon_got.entry_valid != mon_want.entry_valid)
                    report_mismatch("entry_valid", mon_got.entry_valid, mon_want.entry_valid);
                if (mon_got.red != mon_want.red)
                    report_mismatch("red_out", mon_got.red, mon_want.red);
                if (mon_got.green != mon_want.green)
                    report_mismatch("green_out", mon_got.green, mon_want.green);
                if (mon_got.blue != mon_want.blue)
                    report_mismatch("blue_out", mon_got.blue, mon_want.blue);
                if (mon_got.count != mon_want.count)
                    report_mismatch("entry_count", mon_got.count, mon_want.count);
            end
            results_seen++;
        end
    end

    // watchdog: far above the slowest legal run
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        pal_request_t rq;
        logic [14:0]  c;
        int           img_no;
        int           img_len;
        int           pool_size;
        int           roll;
        int           sel_top;
        bit           big;
        bit           pixel_from_pool;

        img_no = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < NUM_DIRECTED; r++) begin
            send_request(directed_rows[r].rq, directed_rows[r].given, directed_rows[r].golden);
            sender_gap();
        end

        // random images: each opens with a start pixel and draws from its own color pool;
        // two big images push the palette past full
        while (requests_sent < RANDOM_TARGET) begin
            big       = (img_no == 1 || img_no == 4);
            pool_size = big ? 320 : $urandom_range(1, 40);
            img_len   = big ? 340 : $urandom_range(4, 60);
            for (int k = 0; k < pool_size; k++)
                color_pool[k] = 15'($urandom);

            for (int k = 0; k < img_len; k++) begin
                roll            = $urandom_range(0, 99);
                rq.req          = rgbpal_pkg::REQ_PIXEL;
                rq.start        = 1'b0;
                rq.red          = 8'($urandom);
                rq.green        = 8'($urandom);
                rq.blue         = 8'($urandom);
                rq.sel          = 8'($urandom);
                pixel_from_pool = 1'b0;
                if (k == 0) begin
                    rq.start        = 1'b1;
                    pixel_from_pool = 1'b1;
                end else if (big && k < pool_size) begin
                    // no stray start or read until the whole pool has been offered
                    pixel_from_pool = 1'b1;
                end else if (roll < 6) begin
                    // noise: any kind, rare stray start flag
                    rq.req   = 1'($urandom);
                    rq.start = ($urandom_range(0, 9) == 0);
                end else if (roll < 22) begin
                    // read-back, mostly near the live count
                    rq.req  = rgbpal_pkg::REQ_READ;
                    sel_top = (model_count + 2 > 255) ? 255 : model_count + 2;
                    if ($urandom_range(0, 3) != 0)
                        rq.sel = 8'($urandom_range(0, sel_top));
                end else begin
                    pixel_from_pool = 1'b1;
                end
                if (pixel_from_pool) begin
                    // big images walk the pool once so the palette surely fills
                    c = (big && k < pool_size) ? color_pool[k]
                                               : color_pool[$urandom_range(0, pool_size - 1)];
                    rq.red   = {c[14:10], rq.red[2:0]};
                    rq.green = {c[9:5], rq.green[2:0]};
                    rq.blue  = {c[4:0], rq.blue[2:0]};
                end

                if (requests_sent == HOLD_AT) begin
                    // result side holds off while requests keep coming back to back
                    long_hold_req = 1'b1;
                    no_gap_left   = 30;
                end
                if (requests_sent == PAUSE_AT) begin
                    // input side pauses until every outstanding result is out
                    @(negedge aclk);
                    s_tvalid <= 1'b0;
                    wait (pending_results.size() == 0);
                end
                if (requests_sent >= QUIET_AT) begin
                    sender_idle_on   = 1'b0;
                    receiver_idle_on = 1'b0;
                end

                send_request(rq, 1'b0, '0);
                sender_gap();
            end
            img_no++;
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        // catch stray results after the last expected one
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: rgb555_palette_indexer.f
+incdir+hdl
hdl/rgbpal_pkg.sv
hdl/rgbpal_mem.sv
hdl/rgbpal_engine.sv
hdl/rgb555_palette_indexer.sv
tb/testbench.sv
